[hw/rtl/mmh_pkg.sv]
// ----------------------------------------------------------------------------
// mmh_pkg
// Shared types and constants of the min-max heap priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package mmh_pkg;

	localparam int DEF_CAPACITY = 64;
	localparam int KEY_W        = 32;
	localparam int CNT_W        = 7;
	localparam int S_TDATA_W    = 40;
	localparam int M_TDATA_W    = 48;

	// command codes on the input stream
	localparam logic [1:0] CMD_INSERT  = 2'd0;
	localparam logic [1:0] CMD_DEL_MIN = 2'd1;
	localparam logic [1:0] CMD_DEL_MAX = 2'd2;

	// status codes on the output stream
	localparam logic [1:0] STAT_DONE  = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	// datapath micro-operations, one per cycle
	typedef enum logic [4:0] {
		OP_NOP,
		OP_LOAD,
		OP_FLAG_FULL,
		OP_FLAG_EMPTY,
		OP_INS_ROOT,
		OP_INS_START,
		OP_INS_PARENT,
		OP_CLIMB,
		OP_TOP2,
		OP_TOP3,
		OP_PICK,
		OP_RD_TOP,
		OP_RD_LAST,
		OP_SETUP,
		OP_SINK_HEAD,
		OP_SCAN,
		OP_DECIDE,
		OP_WR_KEY,
		OP_SINK_PAR,
		OP_FINISH
	} dp_op_t;

	// datapath status seen by the controller
	typedef struct packed {
		logic is_ins;
		logic is_del;
		logic is_del_max;
		logic full;
		logic empty;
		logic ge2;
		logic ge3;
		logic climb_done;
		logic pos_gt_fill;
		logic pos_le_half;
		logic scan_last;
		logic stop;
		logic child;
		logic out_busy;
	} dp_stat_t;

endpackage

`default_nettype wire

[hw/rtl/mmh_dp.sv]
// ----------------------------------------------------------------------------
// mmh_dp
// Heap store, working registers and output register of the priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mmh_dp import mmh_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire dp_op_t               op,
	output dp_stat_t                  stat,
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [M_TDATA_W-1:0]      m_tdata
);

	localparam int AW = $clog2(CAPACITY + 1);
	localparam int CW = AW + 2;

	// heap store, slot 0 unused
	logic signed [KEY_W-1:0] mem [CAPACITY+1];

	logic [1:0]              cmd_q;
	logic signed [KEY_W-1:0] key_q, tmp_q, bestv_q, rd_q, removed_q;
	logic [AW-1:0]           fill_q, pos_q, top_q, best_q, par_q;
	logic                    want_max_q;
	logic [2:0]              cnt_q;
	logic                    v_s1, first_s1;
	logic [AW-1:0]           kidx_s1;
	logic [1:0]              st_q;
	logic [1:0]              out_status_q;
	logic signed [KEY_W-1:0] out_removed_q;
	logic [CNT_W-1:0]        out_count_q;
	logic                    out_valid_q;

	logic                    rd_en, we;
	logic [AW-1:0]           rd_addr, wa;
	logic signed [KEY_W-1:0] wd;

	logic [AW-1:0] ins_n, ins_p, par_pos, new_pos, gp;
	logic          maxp, swap_up, better_c, climb_done;
	logic [CW-1:0] cand;
	logic          cand_ok, better_s, stop, child, swap_p;

	// level of a slot: odd depth is a max level
	function automatic logic max_level(input logic [AW-1:0] idx);
		logic r;
		r = 1'b0;
		for (int i = 0; i < AW; i++) begin
			if (idx[i]) r = i[0];
		end
		return r;
	endfunction

	// decisions of the current step
	always_comb begin
		ins_n    = fill_q + AW'(1);
		ins_p    = ins_n >> 1;
		par_pos  = pos_q >> 1;
		maxp     = max_level(par_pos);
		swap_up  = maxp ? (key_q > rd_q) : (key_q < rd_q);
		new_pos  = swap_up ? par_pos : pos_q;
		gp       = pos_q >> 2;
		better_c = want_max_q ? (key_q > rd_q) : (key_q < rd_q);
		climb_done = (gp == '0) || !better_c;
		if (cnt_q < 3'd2) begin
			cand = {1'b0, pos_q, 1'b0} + CW'(cnt_q[0]);
		end else begin
			cand = {pos_q, 2'b00} + CW'(2'(cnt_q - 3'd2));
		end
		cand_ok  = (cnt_q < 3'd6) && (cand <= CW'(fill_q));
		better_s = want_max_q ? (rd_q > bestv_q) : (rd_q < bestv_q);
		stop     = want_max_q ? (key_q >= bestv_q) : (key_q <= bestv_q);
		child    = (AW+1)'(best_q) <= {pos_q, 1'b1};
		swap_p   = want_max_q ? (key_q < rd_q) : (key_q > rd_q);
	end

	// memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		we      = 1'b0;
		wa      = pos_q;
		wd      = key_q;
		unique case (op)
			OP_INS_ROOT: begin
				we = 1'b1;
				wa = AW'(1);
			end
			OP_INS_START: begin
				rd_en   = 1'b1;
				rd_addr = ins_p;
			end
			OP_INS_PARENT: begin
				rd_en   = 1'b1;
				rd_addr = new_pos >> 2;
				if (swap_up) begin
					we = 1'b1;
					wd = rd_q;
				end
			end
			OP_CLIMB: begin
				we = 1'b1;
				if (!climb_done) begin
					wd      = rd_q;
					rd_en   = 1'b1;
					rd_addr = gp >> 2;
				end
			end
			OP_TOP2: begin
				rd_en   = 1'b1;
				rd_addr = AW'(2);
			end
			OP_TOP3: begin
				rd_en   = 1'b1;
				rd_addr = AW'(3);
			end
			OP_RD_TOP: begin
				rd_en   = 1'b1;
				rd_addr = top_q;
			end
			OP_RD_LAST: begin
				rd_en   = 1'b1;
				rd_addr = fill_q;
			end
			OP_SINK_HEAD: begin
				we = !(pos_q > fill_q) && !(pos_q <= (fill_q >> 1));
			end
			OP_SCAN: begin
				rd_en   = cand_ok;
				rd_addr = cand[AW-1:0];
			end
			OP_DECIDE: begin
				we = 1'b1;
				if (!stop) wd = bestv_q;
				if (!stop && !child) begin
					rd_en   = 1'b1;
					rd_addr = best_q >> 1;
				end
			end
			OP_WR_KEY: we = 1'b1;
			OP_SINK_PAR: begin
				we = swap_p;
				wa = par_q;
			end
			default: ;
		endcase
	end

	// heap store
	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		if (rd_en) rd_q <= mem[rd_addr];
	end

	// working registers without reset
	always_ff @(posedge clk) begin
		unique case (op)
			OP_LOAD: begin
				cmd_q     <= s_tdata[1:0];
				key_q     <= s_tdata[KEY_W+1:2];
				st_q      <= STAT_DONE;
				removed_q <= '0;
				top_q     <= AW'(1);
			end
			OP_FLAG_FULL:  st_q <= STAT_FULL;
			OP_FLAG_EMPTY: st_q <= STAT_EMPTY;
			OP_INS_START:  pos_q <= ins_n;
			OP_INS_PARENT: begin
				pos_q      <= new_pos;
				want_max_q <= swap_up ? maxp : !maxp;
			end
			OP_CLIMB: if (!climb_done) pos_q <= gp;
			OP_TOP2:  top_q <= AW'(2);
			OP_TOP3:  tmp_q <= rd_q;
			OP_PICK:  if (rd_q > tmp_q) top_q <= AW'(3);
			OP_RD_LAST: removed_q <= rd_q;
			OP_SETUP: begin
				key_q      <= rd_q;
				pos_q      <= top_q;
				want_max_q <= (cmd_q == CMD_DEL_MAX) && (top_q != AW'(1));
			end
			OP_SINK_HEAD: begin
				cnt_q <= '0;
				v_s1  <= 1'b0;
			end
			OP_SCAN: begin
				cnt_q    <= cnt_q + 3'd1;
				v_s1     <= cand_ok;
				first_s1 <= (cnt_q == 3'd0);
				kidx_s1  <= cand[AW-1:0];
				if (v_s1 && (first_s1 || better_s)) begin
					best_q  <= kidx_s1;
					bestv_q <= rd_q;
				end
			end
			OP_DECIDE: begin
				if (!stop) pos_q <= best_q;
				par_q <= best_q >> 1;
			end
			OP_SINK_PAR: if (swap_p) key_q <= rd_q;
			default: ;
		endcase
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else begin
			unique case (op)
				OP_INS_ROOT:  fill_q <= AW'(1);
				OP_INS_START: fill_q <= ins_n;
				OP_SETUP:     fill_q <= fill_q - AW'(1);
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (op == OP_FINISH) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (op == OP_FINISH) begin
			out_status_q  <= st_q;
			out_removed_q <= removed_q;
			out_count_q   <= CNT_W'(fill_q);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(M_TDATA_W-CNT_W-KEY_W-2)'(0), out_count_q, out_removed_q, out_status_q};

	// status to the controller
	always_comb begin
		stat.is_ins      = (cmd_q == CMD_INSERT);
		stat.is_del      = (cmd_q == CMD_DEL_MIN) || (cmd_q == CMD_DEL_MAX);
		stat.is_del_max  = (cmd_q == CMD_DEL_MAX);
		stat.full        = (32'(fill_q) >= 32'(CAPACITY));
		stat.empty       = (fill_q == '0);
		stat.ge2         = (fill_q >= AW'(2));
		stat.ge3         = (fill_q >= AW'(3));
		stat.climb_done  = climb_done;
		stat.pos_gt_fill = (pos_q > fill_q);
		stat.pos_le_half = (pos_q <= (fill_q >> 1));
		stat.scan_last   = (cnt_q == 3'd6);
		stat.stop        = stop;
		stat.child       = child;
		stat.out_busy    = out_valid_q && !m_tready;
	end

endmodule

`default_nettype wire

[hw/rtl/mmh_ctrl.sv]
// ----------------------------------------------------------------------------
// mmh_ctrl
// Sequencer of the priority queue: steps the datapath through each command.
// ----------------------------------------------------------------------------
`default_nettype none

module mmh_ctrl import mmh_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     s_tvalid,
	output logic          s_tready,
	input  wire dp_stat_t stat,
	output dp_op_t        op
);

	typedef enum logic [3:0] {
		S_IDLE, S_DISPATCH, S_INS_PAR, S_CLIMB, S_TOP3, S_PICK, S_RD_TOP,
		S_RD_LAST, S_SETUP, S_HEAD, S_SCAN, S_DECIDE, S_WR_KEY, S_SINK_PAR, S_DONE
	} state_t;

	state_t state_q, state_d;

	// next state and datapath operation
	always_comb begin
		state_d = state_q;
		op      = OP_NOP;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					op      = OP_LOAD;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				priority if (stat.is_ins) begin
					priority if (stat.full) begin
						op      = OP_FLAG_FULL;
						state_d = S_DONE;
					end else if (stat.empty) begin
						op      = OP_INS_ROOT;
						state_d = S_DONE;
					end else begin
						op      = OP_INS_START;
						state_d = S_INS_PAR;
					end
				end else if (stat.is_del) begin
					priority if (stat.empty) begin
						op      = OP_FLAG_EMPTY;
						state_d = S_DONE;
					end else if (stat.is_del_max && stat.ge2) begin
						op      = OP_TOP2;
						state_d = stat.ge3 ? S_TOP3 : S_RD_TOP;
					end else begin
						state_d = S_RD_TOP;
					end
				end else begin
					state_d = S_DONE;
				end
			end
			S_INS_PAR: begin
				op      = OP_INS_PARENT;
				state_d = S_CLIMB;
			end
			S_CLIMB: begin
				op = OP_CLIMB;
				if (stat.climb_done) state_d = S_DONE;
			end
			S_TOP3: begin
				op      = OP_TOP3;
				state_d = S_PICK;
			end
			S_PICK: begin
				op      = OP_PICK;
				state_d = S_RD_TOP;
			end
			S_RD_TOP: begin
				op      = OP_RD_TOP;
				state_d = S_RD_LAST;
			end
			S_RD_LAST: begin
				op      = OP_RD_LAST;
				state_d = S_SETUP;
			end
			S_SETUP: begin
				op      = OP_SETUP;
				state_d = S_HEAD;
			end
			S_HEAD: begin
				op = OP_SINK_HEAD;
				priority if (stat.pos_gt_fill) state_d = S_DONE;
				else if (stat.pos_le_half)     state_d = S_SCAN;
				else                           state_d = S_DONE;
			end
			S_SCAN: begin
				op = OP_SCAN;
				if (stat.scan_last) state_d = S_DECIDE;
			end
			S_DECIDE: begin
				op = OP_DECIDE;
				priority if (stat.stop) state_d = S_DONE;
				else if (stat.child)    state_d = S_WR_KEY;
				else                    state_d = S_SINK_PAR;
			end
			S_WR_KEY: begin
				op      = OP_WR_KEY;
				state_d = S_DONE;
			end
			S_SINK_PAR: begin
				op      = OP_SINK_PAR;
				state_d = S_HEAD;
			end
			S_DONE: begin
				if (!stat.out_busy) begin
					op      = OP_FINISH;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign s_tready = (state_q == S_IDLE);

endmodule

`default_nettype wire

[hw/rtl/min_max_heap_depq_top.sv]
// ----------------------------------------------------------------------------
// min_max_heap_depq_top
// Double-ended priority queue kept as a min-max heap in an on-chip store.
// ----------------------------------------------------------------------------
// Each input transaction carries a command (insert, remove minimum, remove
// maximum) and a signed key; each one yields exactly one output transaction
// with a status, the removed key and the entry count after the command.
// Commands are handled one at a time; the heap store serves one read and one
// write per cycle. An insert climbs one grandparent level per step; a removal
// sinks one level of grandchildren per step, and remove maximum with three
// or more keys first compares the two keys below the root. s_tready is high
// only while no command is in work. The result sits in an output register,
// so the next command is taken while a finished result waits; a stalled
// m_tready holds the result stable and holds back the end of the next
// command. Reset empties the heap at once.
// ----------------------------------------------------------------------------
`default_nettype none

module min_max_heap_depq_top import mmh_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [S_TDATA_W-1:0] s_tdata,  // command[1:0], key[33:2]
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [M_TDATA_W-1:0]      m_tdata   // status[1:0], removed_key[33:2],
	                                            // entry_count[40:34]
);

	dp_op_t   op;
	dp_stat_t stat;

	mmh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.op       (op)
	);

	mmh_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (op),
		.stat     (stat),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

`default_nettype wire

[sim/heap_checker.sv]
// ----------------------------------------------------------------------------
// heap_checker
// Watches both streams of the heap queue, predicts each result and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module heap_checker import mmh_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	input  wire logic                 s_tready,
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	input  wire logic                 m_tvalid,
	input  wire logic                 m_tready,
	input  wire logic [M_TDATA_W-1:0] m_tdata,
	output int                        err_count,
	output int                        pending
);

	typedef struct packed {
		logic [1:0]       status;
		logic [KEY_W-1:0] removed_key;
		logic [CNT_W-1:0] entry_count;
	} heap_result_t;

	// predicted heap contents, 1-based
	logic signed [KEY_W-1:0] heap [1:CAPACITY];
	int unsigned fill;
	heap_result_t expected_q[$];

	assign pending = expected_q.size();

	function automatic bit max_level(int unsigned idx);
		int unsigned d;
		d = 0;
		while (idx > 1) begin
			idx = idx >> 1;
			d++;
		end
		return d[0];
	endfunction

	function automatic bit better(logic signed [KEY_W-1:0] a, logic signed [KEY_W-1:0] b,
			bit hi);
		return hi ? (a > b) : (a < b);
	endfunction

	task automatic bubble_up(int unsigned pos, logic signed [KEY_W-1:0] k, bit hi);
		int unsigned gp;
		gp = pos / 4;
		while (gp != 0 && better(k, heap[gp], hi)) begin
			heap[pos] = heap[gp];
			pos = gp;
			gp = pos / 4;
		end
		heap[pos] = k;
	endtask

	function automatic int unsigned best_below(int unsigned pos, bit hi);
		int unsigned best;
		int unsigned c;
		best = 2 * pos;
		for (int i = 0; i < 5; i++) begin
			c = (i == 0) ? 2 * pos + 1 : 4 * pos + i - 1;
			if (c <= fill && c <= CAPACITY && better(heap[c], heap[best], hi))
				best = c;
		end
		return best;
	endfunction

	task automatic trickle_down(int unsigned pos, logic signed [KEY_W-1:0] k, bit hi);
		int unsigned c;
		int unsigned p;
		logic signed [KEY_W-1:0] t;
		while (pos <= fill / 2) begin
			c = best_below(pos, hi);
			if (!better(heap[c], k, hi))
				break;
			heap[pos] = heap[c];
			if (c <= 2 * pos + 1) begin
				pos = c;
				break;
			end
			p = c / 2;
			if (better(heap[p], k, hi)) begin
				t = heap[p];
				heap[p] = k;
				k = t;
			end
			pos = c;
		end
		if (pos <= CAPACITY)
			heap[pos] = k;
	endtask

	task automatic run_command(logic [1:0] cmd, logic signed [KEY_W-1:0] k);
		heap_result_t r;
		int unsigned n;
		int unsigned p;
		int unsigned top;
		logic signed [KEY_W-1:0] last;
		r = '0;
		if (cmd == CMD_INSERT) begin
			if (fill >= CAPACITY) begin
				r.status = STAT_FULL;
			end else begin
				fill++;
				n = fill;
				p = n / 2;
				if (p == 0) begin
					heap[1] = k;
				end else if (!max_level(p)) begin
					if (k < heap[p]) begin
						heap[n] = heap[p];
						bubble_up(p, k, 1'b0);
					end else begin
						bubble_up(n, k, 1'b1);
					end
				end else begin
					if (k > heap[p]) begin
						heap[n] = heap[p];
						bubble_up(p, k, 1'b1);
					end else begin
						bubble_up(n, k, 1'b0);
					end
				end
			end
		end else if (cmd == CMD_DEL_MIN || cmd == CMD_DEL_MAX) begin
			if (fill == 0) begin
				r.status = STAT_EMPTY;
			end else begin
				top = 1;
				if (cmd == CMD_DEL_MAX) begin
					if (fill >= 2)
						top = 2;
					if (fill >= 3 && heap[3] > heap[2])
						top = 3;
				end
				r.removed_key = heap[top];
				last = heap[fill];
				fill--;
				if (top <= fill)
					trickle_down(top, last, cmd == CMD_DEL_MAX && top != 1);
			end
		end
		r.entry_count = fill[CNT_W-1:0];
		expected_q.push_back(r);
	endtask

	// predict on each input transaction, compare on each output transaction
	always @(posedge clk or negedge arst_n) begin
		heap_result_t got;
		heap_result_t exp_r;
		if (!arst_n) begin
			fill = 0;
			err_count = 0;
			expected_q.delete();
		end else begin
			if (s_tvalid && s_tready)
				run_command(s_tdata[1:0], s_tdata[33:2]);
			if (m_tvalid && m_tready) begin
				got.status      = m_tdata[1:0];
				got.removed_key = m_tdata[33:2];
				got.entry_count = m_tdata[40:34];
				if (expected_q.size() == 0) begin
					err_count++;
					if (err_count <= 10)
						$display("unexpected result: %h", got);
				end else begin
					exp_r = expected_q.pop_front();
					if (got !== exp_r) begin
						err_count++;
						if (err_count <= 10)
							$display("mismatch: exp st=%0d key=%0d cnt=%0d, got st=%0d key=%0d cnt=%0d",
								exp_r.status, $signed(exp_r.removed_key), exp_r.entry_count,
								got.status, $signed(got.removed_key), got.entry_count);
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the min-max heap queue: directed corner commands, then random
// fill/drain phases, with random idling on both streams and a long stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_top import mmh_pkg::*;;

	localparam int CAP = DEF_CAPACITY;
	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	int err_count;
	int pending;
	int cycles;
	bit quiet;       // no idling in the final stretch
	bit hold_sink;   // long receiver stall request

	min_max_heap_depq_top #(.CAPACITY(CAP)) uut (.*);

	heap_checker #(.CAPACITY(CAP)) chk (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata,
		.m_tvalid, .m_tready, .m_tdata, .err_count, .pending
	);

	initial clk = 0;
	always #5 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// receiver: random stall bursts, or a long hold-off on request
	initial begin
		int n;
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			if (hold_sink) begin
				m_tready <= 0;
				repeat (300) @(posedge clk);
				hold_sink = 0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 11);
				m_tready <= 0;
				repeat (n) @(posedge clk);
			end else begin
				m_tready <= 1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	task automatic send(logic [1:0] cmd, logic [KEY_W-1:0] k, bit gaps);
		int n;
		if (gaps && !quiet && $urandom_range(0, 4) == 0) begin
			n = $urandom_range(1, 11);
			s_tvalid <= 0;
			repeat (n) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {6'b0, k, cmd};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic drain_all();
		s_tvalid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	function automatic logic [KEY_W-1:0] rand_key();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 15);      // many ties
			1: return 32'h8000_0000 + $urandom_range(0, 3);
			2: return 32'h7fff_fffc + $urandom_range(0, 3);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int sent;
		logic [1:0] cmd;
		cycles = 0;
		quiet = 0;
		hold_sink = 0;
		s_tvalid = 0;
		s_tdata = '0;
		arst_n = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: removals from empty, extremes, unused code, ties
		send(CMD_DEL_MIN, '0, 0);
		send(CMD_DEL_MAX, '0, 0);
		send(CMD_INSERT, 32'h8000_0000, 0);
		send(CMD_DEL_MAX, '0, 0);
		send(CMD_INSERT, 32'h7fff_ffff, 0);
		send(CMD_INSERT, 32'h8000_0000, 0);
		send(CMD_INSERT, 32'hffff_ffff, 0);
		send(CMD_INSERT, 32'h7fff_ffff, 0);
		send(2'd3, 32'h5555_aaaa, 0);
		send(CMD_DEL_MAX, '0, 0);
		send(CMD_DEL_MIN, '0, 0);
		send(CMD_DEL_MAX, '0, 0);
		send(CMD_DEL_MIN, '0, 0);
		send(CMD_DEL_MIN, '0, 0);
		send(2'd3, 32'haaaa_5555, 0);
		drain_all();

		// fill past capacity under a long receiver stall, then drain
		hold_sink = 1;
		for (int i = 0; i < CAP + 3; i++)
			send(CMD_INSERT, rand_key(), 0);
		for (int i = 0; i < CAP + 2; i++)
			send($urandom_range(0, 1) ? CMD_DEL_MAX : CMD_DEL_MIN, $urandom, 1);
		drain_all();

		// random phases: insert-heavy, then removal-heavy
		sent = 0;
		while (sent < 780) begin
			if (sent > 660)
				quiet = 1;
			for (int i = 0; i < 60; i++) begin
				if ((sent / 60) % 2 == 0)
					cmd = ($urandom_range(0, 9) < 7) ? CMD_INSERT :
						($urandom_range(0, 1) ? CMD_DEL_MIN : CMD_DEL_MAX);
				else
					cmd = ($urandom_range(0, 9) < 3) ? CMD_INSERT :
						($urandom_range(0, 1) ? CMD_DEL_MIN : CMD_DEL_MAX);
				if ($urandom_range(0, 40) == 0)
					cmd = 2'd3;
				send(cmd, rand_key(), 1);
				sent++;
			end
			if (!quiet && $urandom_range(0, 4) == 0)
				drain_all();
		end

		drain_all();
		repeat (100) @(posedge clk);
		if (err_count == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire

[files.f]
hw/rtl/mmh_pkg.sv
hw/rtl/mmh_dp.sv
hw/rtl/mmh_ctrl.sv
hw/rtl/min_max_heap_depq_top.sv
sim/heap_checker.sv
sim/tb_top.sv
